/* sv/ust_pkg.sv */
// ----------------------------------------------------------------------------
// ust_pkg
// Types and codes shared by the unordered set table: transaction payloads,
// operation and status codes, register map and controller states.
// ----------------------------------------------------------------------------
package ust_pkg;

   // Operation codes
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_SEARCH = 2'd2;

   // Status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   // Register map: word index taken from paddr[2]
   localparam logic       REG_CAPACITY   = 1'b0;
   localparam int         CAP_WIDTH      = 5;
   localparam logic [4:0] CAPACITY_RESET = 5'd16;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] value;
   } ust_req_type;

   typedef struct packed {
      logic [1:0] status;
      logic       hit;
      logic [4:0] entry_count;
      logic       is_empty;
      logic       is_full;
   } ust_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MOVE,
      ST_DONE
   } ust_state_type;

endpackage

/* sv/unordered_set_table.sv */
// ----------------------------------------------------------------------------
// unordered_set_table
// Unsorted table of up to DEPTH values with a run-time capacity limit.
// Insert appends, delete swaps the last entry into the matching slot,
// search reports presence. One result per request.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_ready  ust_req_type (operation, value)
//   rsp_      out        rsp_valid / rsp_ready  ust_rsp_type (status, hit, count, flags)
//   csr_      in/out     APB, pready tied high  capacity at byte address 0
//
// Insert and refused operations go from idle straight to the result state.
// Search and delete stream the entry memory through its single read port,
// one entry per cycle, then hand the result on; a delete hit adds a move of
// the last entry into the matching slot.
// Reset clears the count and restores capacity to 16; entry contents are not
// cleared. A new request is taken once the previous result sits in the output
// register; a stalled rsp_ready holds the controller in its final state.
// ----------------------------------------------------------------------------
module unordered_set_table #(
   parameter int DEPTH       = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_ready,
   input  ust_pkg::ust_req_type req_payload,

   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ust_pkg::ust_rsp_type rsp_payload,

   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [2:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > ust_pkg::CAP_WIDTH) ? CW : ust_pkg::CAP_WIDTH;

   // Entry memory
   logic [VALUE_WIDTH-1:0] mem [DEPTH];
   logic [VALUE_WIDTH-1:0] rd_data_ff;
   logic                   rd_en;
   logic [AW-1:0]          rd_addr;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [VALUE_WIDTH-1:0] wr_data;

   ust_pkg::ust_state_type state_ff, state_in;

   logic [CW-1:0]          count_ff;
   logic [CW-1:0]          count_dec;
   logic [AW-1:0]          last_idx;
   logic [4:0]             cap_ff;
   logic [1:0]             op_ff;
   logic [VALUE_WIDTH-1:0] key_ff;
   logic [VALUE_WIDTH-1:0] key_in;
   logic [CW-1:0]          issue_idx_ff;
   logic                   cmp_vld_ff;
   logic [AW-1:0]          cmp_idx_ff;
   logic                   hit_ff;
   logic [AW-1:0]          hit_idx_ff;
   logic [1:0]             status_ff;
   logic [1:0]             status_in;
   logic                   rsp_valid_ff;
   ust_pkg::ust_rsp_type   rsp_payload_ff;
   ust_pkg::ust_rsp_type   rsp_in;

   logic req_take;
   logic full;
   logic insert_ok;
   logic match;
   logic scan_end;
   logic issue_go;
   logic rsp_load;
   logic csr_write;

   // ------------------------------------------------------------------
   // Configuration port
   // ------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == ust_pkg::REG_CAPACITY) ? 32'(cap_ff) : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= ust_pkg::CAPACITY_RESET;
      end else if (csr_write && csr_paddr[2] == ust_pkg::REG_CAPACITY) begin
         cap_ff <= csr_pwdata[4:0];
      end
   end

   // ------------------------------------------------------------------
   // Datapath helpers
   // ------------------------------------------------------------------
   assign key_in    = VALUE_WIDTH'(req_payload.value);
   assign count_dec = count_ff - CW'(1);
   assign last_idx  = count_dec[AW-1:0];
   // count never exceeds DEPTH, so full against the saturated capacity
   // reduces to these two compares
   assign full      = (count_ff == CW'(DEPTH)) || (XW'(count_ff) >= XW'(cap_ff));
   assign req_take  = req_valid && req_ready;
   assign insert_ok = (req_payload.operation == ust_pkg::OP_INSERT) && !full;

   assign match     = cmp_vld_ff && (rd_data_ff == key_ff);
   assign scan_end  = cmp_vld_ff && (cmp_idx_ff == last_idx);
   assign issue_go  = (state_ff == ust_pkg::ST_SCAN) && !match
                      && (issue_idx_ff < count_ff);
   assign rsp_load  = (state_ff == ust_pkg::ST_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      if (req_payload.operation == ust_pkg::OP_INSERT && full) begin
         status_in = ust_pkg::STATUS_FULL;
      end else if (req_payload.operation == ust_pkg::OP_DELETE && count_ff == '0) begin
         status_in = ust_pkg::STATUS_EMPTY;
      end else begin
         status_in = ust_pkg::STATUS_OK;
      end
   end

   // ------------------------------------------------------------------
   // Controller: next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ust_pkg::ST_IDLE: begin
            if (req_take) begin
               if ((req_payload.operation == ust_pkg::OP_DELETE
                    || req_payload.operation == ust_pkg::OP_SEARCH)
                   && count_ff != '0) begin
                  state_in = ust_pkg::ST_SCAN;
               end else begin
                  state_in = ust_pkg::ST_DONE;
               end
            end
         end
         ust_pkg::ST_SCAN: begin
            if (match) begin
               state_in = (op_ff == ust_pkg::OP_DELETE) ? ust_pkg::ST_MOVE
                                                        : ust_pkg::ST_DONE;
            end else if (scan_end) begin
               state_in = ust_pkg::ST_DONE;
            end
         end
         ust_pkg::ST_MOVE: begin
            state_in = ust_pkg::ST_DONE;
         end
         ust_pkg::ST_DONE: begin
            if (rsp_load) begin
               state_in = ust_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ust_pkg::ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Controller: memory port and handshake outputs
   // ------------------------------------------------------------------
   always_comb begin
      req_ready = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = '0;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = key_in;
      case (state_ff)
         ust_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            wr_en     = req_take && insert_ok;
            wr_addr   = count_ff[AW-1:0];
            wr_data   = key_in;
         end
         ust_pkg::ST_SCAN: begin
            if (match && op_ff == ust_pkg::OP_DELETE) begin
               // fetch the last entry to fill the hole
               rd_en   = 1'b1;
               rd_addr = last_idx;
            end else begin
               rd_en   = issue_go;
               rd_addr = issue_idx_ff[AW-1:0];
            end
         end
         ust_pkg::ST_MOVE: begin
            wr_en   = 1'b1;
            wr_addr = hit_idx_ff;
            wr_data = rd_data_ff;
         end
         ust_pkg::ST_DONE: begin
            req_ready = 1'b0;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Memory
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // ------------------------------------------------------------------
   // Control registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ust_pkg::ST_IDLE;
         count_ff     <= '0;
         issue_idx_ff <= '0;
         cmp_vld_ff   <= 1'b0;
         hit_ff       <= 1'b0;
         status_ff    <= ust_pkg::STATUS_OK;
      end else begin
         state_ff <= state_in;
         if (req_take) begin
            issue_idx_ff <= '0;
            cmp_vld_ff   <= 1'b0;
            hit_ff       <= 1'b0;
            status_ff    <= status_in;
            if (insert_ok) begin
               count_ff <= count_ff + CW'(1);
            end
         end
         if (state_ff == ust_pkg::ST_SCAN) begin
            cmp_vld_ff <= issue_go;
            if (issue_go) begin
               issue_idx_ff <= issue_idx_ff + CW'(1);
            end
            if (match) begin
               hit_ff <= 1'b1;
            end
         end
         if (state_ff == ust_pkg::ST_MOVE) begin
            count_ff <= count_dec;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff  <= req_payload.operation;
         key_ff <= key_in;
      end
      if (issue_go) begin
         cmp_idx_ff <= issue_idx_ff[AW-1:0];
      end
      if (match) begin
         hit_idx_ff <= cmp_idx_ff;
      end
   end

   // ------------------------------------------------------------------
   // Result register
   // ------------------------------------------------------------------
   always_comb begin
      rsp_in.status      = status_ff;
      rsp_in.hit         = hit_ff;
      rsp_in.entry_count = 5'(count_ff);
      rsp_in.is_empty    = (count_ff == '0);
      rsp_in.is_full     = full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_payload_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for unordered_set_table. A directed pass covers the
// empty and full cases, value extremes, every operation and the capacity
// corner cases. Random phases then sweep capacity settings with fill- and
// drain-biased traffic, and a long response hold-off backs up the input.
// Every result is checked against a local model of the table.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int          TABLE_DEPTH   = 16;
   localparam logic [1:0]  OP_NOP        = 2'd3;
   localparam logic [2:0]  ADDR_CAPACITY = {ust_pkg::REG_CAPACITY, 2'b00};
   localparam logic [2:0]  ADDR_UNMAPPED = 3'd4;
   localparam int unsigned CYCLE_LIMIT   = 500000;
   localparam int          PHASES        = 13;
   localparam int          PHASE_ITEMS   = 50;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   ust_pkg::ust_req_type req_payload;
   logic                 rsp_valid;
   logic                 rsp_ready;
   ust_pkg::ust_rsp_type rsp_payload;
   logic                 csr_psel;
   logic                 csr_penable;
   logic                 csr_pwrite;
   logic [2:0]           csr_paddr;
   logic [31:0]          csr_pwdata;
   logic [31:0]          csr_prdata;
   logic                 csr_pready;

   // Local copy of the table state
   logic [31:0] table_vals [TABLE_DEPTH];
   int unsigned table_count;
   logic [4:0]  cap_reg;

   ust_pkg::ust_rsp_type expected_rsp [$];
   int unsigned errors;
   int unsigned cycles;
   int unsigned hold_request;
   bit          req_idle_on;
   bit          rsp_throttle;

   unordered_set_table u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("unordered_set_table regression: fail");
         $finish;
      end
   end

   // Mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r < 12) return 0;
      if (r < 18) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         errors++;
         $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      end
   endfunction

   // Apply one operation to the local table and return the result it gives
   function automatic ust_pkg::ust_rsp_type apply_op(logic [1:0] op, logic [31:0] val);
      ust_pkg::ust_rsp_type r;
      int unsigned eff_cap;
      int unsigned pos;
      r = '0;
      eff_cap = (cap_reg > TABLE_DEPTH) ? TABLE_DEPTH : cap_reg;
      pos = table_count;
      for (int i = 0; i < table_count; i++)
         if (table_vals[i] == val && pos == table_count) pos = i;
      case (op)
         ust_pkg::OP_INSERT: begin
            if (table_count >= eff_cap) begin
               r.status = ust_pkg::STATUS_FULL;
            end else begin
               table_vals[table_count] = val;
               table_count++;
            end
         end
         ust_pkg::OP_DELETE: begin
            if (table_count == 0) begin
               r.status = ust_pkg::STATUS_EMPTY;
            end else if (pos < table_count) begin
               r.hit = 1'b1;
               table_count--;
               table_vals[pos] = table_vals[table_count];
            end
         end
         ust_pkg::OP_SEARCH: r.hit = (pos < table_count);
         default: ;
      endcase
      r.entry_count = 5'(table_count);
      r.is_empty    = (table_count == 0);
      r.is_full     = (table_count >= eff_cap);
      return r;
   endfunction

   // Leaves req_valid high after acceptance; a drain lowers it, the next call only for a gap
   task automatic send_op(input logic [1:0] op, input logic [31:0] val);
      int unsigned gap;
      gap = req_idle_on ? pick_gap() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{operation: op, value: val};
      do @(posedge clock); while (!(req_valid && req_ready));
      expected_rsp.push_back(apply_op(op, val));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_access(input bit wr, input logic [2:0] addr, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (!wr)
         check_field("capacity readback", cap_reg, csr_prdata[ust_pkg::CAP_WIDTH-1:0]);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (wr && addr[2] == ust_pkg::REG_CAPACITY) cap_reg = data[ust_pkg::CAP_WIDTH-1:0];
      // bus goes idle between accesses
      @(posedge clock);
   endtask

   // Response side: random stalls plus an optional long hold-off
   initial begin : rsp_side
      int unsigned stall_left;
      int unsigned hold_left;
      stall_left = 0;
      hold_left  = 0;
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left == 0 && stall_left == 0 && rsp_throttle && $urandom_range(0, 3) == 0)
            stall_left = pick_gap();
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      ust_pkg::ust_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            errors++;
            $display("%0t: unexpected result %p", $time, rsp_payload);
         end else begin
            want = expected_rsp.pop_front();
            check_field("status", want.status, rsp_payload.status);
            check_field("hit", want.hit, rsp_payload.hit);
            check_field("entry_count", want.entry_count, rsp_payload.entry_count);
            check_field("is_empty", want.is_empty, rsp_payload.is_empty);
            check_field("is_full", want.is_full, rsp_payload.is_full);
         end
      end
   end

   task automatic test_basic_ops();
      send_op(ust_pkg::OP_SEARCH, 32'h0000_0000);   // search on empty table
      send_op(ust_pkg::OP_DELETE, 32'h0000_0000);   // delete on empty table
      send_op(ust_pkg::OP_INSERT, 32'h0000_0000);
      send_op(ust_pkg::OP_INSERT, 32'hFFFF_FFFF);
      send_op(ust_pkg::OP_INSERT, 32'hAAAA_AAAA);
      send_op(ust_pkg::OP_INSERT, 32'h5555_5555);
      send_op(ust_pkg::OP_SEARCH, 32'hFFFF_FFFF);
      send_op(ust_pkg::OP_SEARCH, 32'h0001_2345);
      send_op(ust_pkg::OP_DELETE, 32'h0001_2345);   // miss leaves table alone
      send_op(ust_pkg::OP_DELETE, 32'h0000_0000);   // last entry moves into slot 0
      send_op(ust_pkg::OP_SEARCH, 32'h5555_5555);
      send_op(OP_NOP,             32'hDEAD_BEEF);
      send_op(ust_pkg::OP_INSERT, 32'hAAAA_AAAA);   // duplicate
      send_op(ust_pkg::OP_DELETE, 32'hAAAA_AAAA);
      send_op(ust_pkg::OP_SEARCH, 32'hAAAA_AAAA);
      wait_drained();
   endtask

   task automatic test_capacity();
      csr_access(1'b0, ADDR_CAPACITY, '0);
      csr_access(1'b1, ADDR_CAPACITY, 32'd2);   // below current count
      send_op(ust_pkg::OP_INSERT, 32'h1234_5678);
      send_op(ust_pkg::OP_SEARCH, 32'h5555_5555);
      wait_drained();
      csr_access(1'b1, ADDR_CAPACITY, 32'd0);   // always full
      send_op(ust_pkg::OP_INSERT, 32'h0F0F_0F0F);
      wait_drained();
      csr_access(1'b1, ADDR_UNMAPPED, 32'd31);  // must be ignored
      send_op(ust_pkg::OP_INSERT, 32'h0F0F_0F0F);
      wait_drained();
      csr_access(1'b1, ADDR_CAPACITY, 32'hFFFF_FFF1); // masks to 17, saturates
      csr_access(1'b0, ADDR_CAPACITY, '0);
      send_op(ust_pkg::OP_INSERT, 32'h0F0F_0F0F);
      send_op(ust_pkg::OP_DELETE, 32'hFFFF_FFFF);
      send_op(ust_pkg::OP_DELETE, 32'h5555_5555);
      send_op(ust_pkg::OP_DELETE, 32'hAAAA_AAAA);
      send_op(ust_pkg::OP_DELETE, 32'h0F0F_0F0F);
      wait_drained();
   endtask

   task automatic test_random_phases();
      logic [31:0] pool [8];
      logic [4:0]  fixed_caps [5];
      logic [4:0]  cap;
      logic [1:0]  op;
      logic [31:0] val;
      int unsigned ins_pct;
      int unsigned r;
      fixed_caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17};
      for (int ph = 0; ph < PHASES; ph++) begin
         cap = (ph < 5) ? fixed_caps[ph] : 5'($urandom_range(0, 31));
         csr_access(1'b1, ADDR_CAPACITY, ($urandom & 32'hFFFF_FFE0) | 32'(cap));
         csr_access(1'b0, ADDR_CAPACITY, '0);
         pool[0] = 32'h0000_0000;
         pool[1] = 32'hFFFF_FFFF;
         for (int k = 2; k < 8; k++) pool[k] = $urandom;
         ins_pct      = (ph % 3 == 0) ? 70 : (ph % 3 == 1) ? 25 : 45;
         req_idle_on  = (ph % 4 != 3);
         rsp_throttle = (ph % 4 != 2);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            r = $urandom_range(0, 99);
            if (r < 4)
               op = OP_NOP;
            else if (r < ins_pct)
               op = ust_pkg::OP_INSERT;
            else if (r < ins_pct + (100 - ins_pct) / 2)
               op = ust_pkg::OP_DELETE;
            else
               op = ust_pkg::OP_SEARCH;
            val = ($urandom_range(0, 4) != 0) ? pool[$urandom_range(0, 7)] : $urandom;
            send_op(op, val);
         end
         wait_drained();
      end
   endtask

   task automatic test_backpressure();
      req_idle_on  = 1'b0;
      rsp_throttle = 1'b0;
      hold_request = 200;
      for (int n = 0; n < 24; n++)
         send_op(2'($urandom_range(0, 2)), $urandom_range(0, 3));
      wait_drained();
      req_idle_on  = 1'b1;
      rsp_throttle = 1'b1;
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_payload  = '0;
      rsp_ready    = 1'b0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      errors       = 0;
      cycles       = 0;
      hold_request = 0;
      req_idle_on  = 1'b1;
      rsp_throttle = 1'b1;
      table_count  = 0;
      cap_reg      = ust_pkg::CAPACITY_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_ops();
      test_capacity();
      test_random_phases();
      test_backpressure();

      repeat (30) @(posedge clock);
      if (errors == 0)
         $display("unordered_set_table regression: pass");
      else
         $display("unordered_set_table regression: fail");
      $finish;
   end

endmodule
